// ===== hdl/mbt_pkg.sv =====
`default_nettype none

package mbt_pkg;

    // Message kinds (upper nibble of the status byte)
    localparam logic [3:0] KIND_NOTE_OFF = 4'h8;
    localparam logic [3:0] KIND_NOTE_ON  = 4'h9;
    localparam logic [3:0] KIND_CC       = 4'hB;
    localparam logic [3:0] KIND_BEND     = 4'hE;

    // Controller numbers
    localparam logic [6:0] CC_ALL_NOTES_OFF = 7'd123;
    localparam logic [6:0] CC_RPN_MSB       = 7'd101;
    localparam logic [6:0] CC_RPN_LSB       = 7'd100;
    localparam logic [6:0] CC_DATA_ENTRY    = 7'd6;

    // Configuration register indexes
    localparam logic CFG_ENABLE      = 1'b0;
    localparam logic CFG_OUT_CHANNEL = 1'b1;

    localparam logic [7:0] RANGE_RESET = 8'd24;

    // Transpose arithmetic: acc = 2*range*(bend-8192) + 16383 + 128*32766,
    // then acc / 32766 by restoring division over 8 quotient bits.
    localparam int          ACC_W       = 24;
    localparam int          BEND_SPAN   = 16383;
    localparam int          DEN         = 2 * BEND_SPAN;
    localparam logic [23:0] ACC_OFFSET  = 24'(BEND_SPAN + 128 * DEN);
    localparam logic [23:0] DIV_INIT    = 24'(-(DEN * 128));

    // One note record: playing flag and the signed shift given at note-on
    typedef struct packed {
        logic       playing;
        logic [7:0] shift;
    } note_entry_t;

endpackage

`default_nettype wire

// ===== hdl/midi_bend_to_transpose.sv =====
// Path: a note-on passes DECODE, then EMIT; a note-off passes DECODE, READ, EMIT; CC123
// passes DECODE, SWEEP, EMIT. Flow: one word at a time, s_ready high only when idle;
// the next word is taken only once the last one is done, which EMIT delays while m_ stalls.
// A bend on channels 1..CHANNELS-1 emits nothing: one shared 24-bit adder runs an 8-step
// multiply, then an 8-step division.
// Reset: synchronous, active low; the note memory is then cleared, 2048 records by default.
`default_nettype none

module midi_bend_to_transpose #(
    parameter int CHANNELS = 16
) (
    input  wire logic       aclk,
    input  wire logic       aresetn,

    input  wire logic       cfg_wr_en,
    input  wire logic       cfg_index,
    input  wire logic [4:0] cfg_data,

    input  wire logic       s_valid,
    output logic            s_ready,
    input  wire logic [7:0] s_status_byte,
    input  wire logic [6:0] s_data_one,
    input  wire logic [6:0] s_data_two,

    output logic            m_valid,
    input  wire logic       m_ready,
    output logic [7:0]      m_out_status,
    output logic [6:0]      m_out_data_one,
    output logic [6:0]      m_out_data_two
);

    localparam int CH_W       = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
    localparam int ADDR_W     = CH_W + 7;
    localparam int NOTE_DEPTH = (1 << CH_W) * 128;

    typedef enum logic [2:0] {
        ST_CLEAR,   // sweep the note memory after reset
        ST_IDLE,    // wait for a word
        ST_DECODE,  // act on the held word
        ST_READ,    // note-off: note record is back from memory
        ST_SWEEP,   // CC123: clear the channel's 128 note records
        ST_MUL,     // shift-add multiply of range by 2*(bend - 8192)
        ST_DIV,     // restoring division by 32766
        ST_EMIT     // hand the result word to the output register
    } state_t;

    state_t                 state_reg;

    // Configuration
    logic                   enable_reg;
    logic [4:0]             dest_chan_reg;

    // Held input word
    logic [7:0]             status_reg;
    logic [3:0]             kind_reg;
    logic [6:0]             d1_reg;
    logic [6:0]             d2_reg;
    logic [7:0]             shift_reg;

    // Per-channel state; the bend range is shared by all channels
    logic [7:0]             chan_shift_reg [CHANNELS];
    logic [CHANNELS-1:0]    coarse_set_reg;
    logic [CHANNELS-1:0]    coarse_zero_reg;
    logic [CHANNELS-1:0]    rpn_set_reg;
    logic [CHANNELS-1:0]    rpn_zero_reg;
    logic [7:0]             bend_range_reg;

    // Sequencer and shared arithmetic unit
    logic [ADDR_W-1:0]      sweep_reg;
    logic [2:0]             cnt_reg;
    logic [mbt_pkg::ACC_W-1:0] acc_reg;
    logic [mbt_pkg::ACC_W-1:0] mcand_reg;
    logic [7:0]             mplr_reg;
    logic signed [mbt_pkg::ACC_W-1:0] dvs_reg;
    logic [7:0]             quo_reg;
    logic [mbt_pkg::ACC_W-1:0] addend;
    logic [mbt_pkg::ACC_W-1:0] sum;
    logic [7:0]             quo_next;

    // Output register
    logic                   m_valid_reg;
    logic [7:0]             m_status_reg;
    logic [6:0]             m_d1_reg;
    logic [6:0]             m_d2_reg;

    // Note memory
    mbt_pkg::note_entry_t   note_mem [NOTE_DEPTH];
    mbt_pkg::note_entry_t   rd_data_reg;
    logic                   mem_we;
    logic [ADDR_W-1:0]      mem_waddr;
    mbt_pkg::note_entry_t   mem_wdata;

    // Decode of the held word
    logic [3:0]             ch;
    logic [CH_W-1:0]        ch_idx;
    logic                   has_state;
    logic [3:0]             och;
    logic [ADDR_W-1:0]      item_addr;
    logic [13:0]            bend_delta;
    logic [3:0]             kind_in;

    assign ch         = status_reg[3:0];
    assign ch_idx     = ch[CH_W-1:0];
    assign has_state  = ({1'b0, ch} < 5'(CHANNELS));
    assign och        = dest_chan_reg[4] ? ch : dest_chan_reg[3:0];
    assign item_addr  = {ch_idx, d1_reg};
    // bend - 8192 as a signed 14-bit value: flip the top bit
    assign bend_delta = {~d2_reg[6], d2_reg[5:0], d1_reg};

    // Treat a note-on with zero velocity as note-off
    assign kind_in = (s_status_byte[7:4] == mbt_pkg::KIND_NOTE_ON && s_data_two == 7'd0)
                     ? mbt_pkg::KIND_NOTE_OFF : s_status_byte[7:4];

    // Shared adder: partial products during the multiply, the negated
    // divisor during the division
    assign addend   = (state_reg == ST_MUL) ? (mplr_reg[0] ? mcand_reg : '0)
                                            : dvs_reg;
    assign sum      = acc_reg + addend;
    assign quo_next = {quo_reg[6:0], ~sum[mbt_pkg::ACC_W-1]};

    assign s_ready        = (state_reg == ST_IDLE);
    assign m_valid        = m_valid_reg;
    assign m_out_status   = m_status_reg;
    assign m_out_data_one = m_d1_reg;
    assign m_out_data_two = m_d2_reg;

    // Note memory write port
    always_comb begin
        mem_we    = 1'b0;
        mem_waddr = item_addr;
        mem_wdata = '0;
        unique case (state_reg)
            ST_CLEAR, ST_SWEEP: begin
                mem_we    = 1'b1;
                mem_waddr = sweep_reg;
            end
            ST_DECODE: begin
                // record the shift given to this note
                if (kind_reg == mbt_pkg::KIND_NOTE_ON && has_state) begin
                    mem_we            = 1'b1;
                    mem_wdata.playing = 1'b1;
                    mem_wdata.shift   = chan_shift_reg[ch_idx];
                end
            end
            ST_READ: begin
                // drop the record once the note is released
                mem_we = 1'b1;
            end
            default: begin
                mem_we = 1'b0;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (mem_we) begin
            note_mem[mem_waddr] <= mem_wdata;
        end
        rd_data_reg <= note_mem[item_addr];
    end

    // Sequencer, per-channel state and output register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg       <= ST_CLEAR;
            sweep_reg       <= '0;
            enable_reg      <= 1'b1;
            dest_chan_reg   <= 5'd0;
            m_valid_reg     <= 1'b0;
            coarse_set_reg  <= '0;
            coarse_zero_reg <= '0;
            rpn_set_reg     <= '0;
            rpn_zero_reg    <= '0;
            bend_range_reg  <= mbt_pkg::RANGE_RESET;
            for (int i = 0; i < CHANNELS; i++) begin
                chan_shift_reg[i] <= 8'd0;
            end
        end else begin
            if (cfg_wr_en) begin
                unique case (cfg_index)
                    mbt_pkg::CFG_ENABLE:      enable_reg    <= cfg_data[0];
                    mbt_pkg::CFG_OUT_CHANNEL: dest_chan_reg <= cfg_data;
                endcase
            end

            // Retire the output word once taken, unless a new one is loaded now
            if (m_ready && state_reg != ST_EMIT) begin
                m_valid_reg <= 1'b0;
            end

            unique case (state_reg)
                ST_CLEAR: begin
                    sweep_reg <= sweep_reg + 1'b1;
                    if (&sweep_reg) begin
                        state_reg <= ST_IDLE;
                    end
                end

                ST_IDLE: begin
                    status_reg <= s_status_byte;
                    kind_reg   <= kind_in;
                    d1_reg     <= s_data_one;
                    d2_reg     <= s_data_two;
                    // With the block disabled, drop the word untouched
                    if (s_valid && enable_reg) begin
                        state_reg <= ST_DECODE;
                    end
                end

                ST_DECODE: begin
                    priority if (kind_reg == mbt_pkg::KIND_BEND && ch != 4'd0) begin
                        // Bend on a transposing channel: start the multiply
                        acc_reg   <= mbt_pkg::ACC_OFFSET;
                        mcand_reg <= {{9{bend_delta[13]}}, bend_delta, 1'b0};
                        mplr_reg  <= bend_range_reg;
                        dvs_reg   <= mbt_pkg::DIV_INIT;
                        cnt_reg   <= 3'd0;
                        state_reg <= has_state ? ST_MUL : ST_IDLE;
                    end else if (kind_reg == mbt_pkg::KIND_NOTE_ON) begin
                        shift_reg <= has_state ? chan_shift_reg[ch_idx] : 8'd0;
                        state_reg <= ST_EMIT;
                    end else if (kind_reg == mbt_pkg::KIND_NOTE_OFF && has_state) begin
                        state_reg <= ST_READ;
                    end else if (kind_reg == mbt_pkg::KIND_CC && has_state
                                 && d1_reg == mbt_pkg::CC_ALL_NOTES_OFF) begin
                        shift_reg <= 8'd0;
                        sweep_reg <= {ch_idx, 7'd0};
                        state_reg <= ST_SWEEP;
                    end else begin
                        shift_reg <= 8'd0;
                        state_reg <= ST_EMIT;
                        if (kind_reg == mbt_pkg::KIND_CC && has_state) begin
                            priority if (d1_reg == mbt_pkg::CC_RPN_MSB) begin
                                coarse_set_reg[ch_idx]  <= 1'b1;
                                coarse_zero_reg[ch_idx] <= (d2_reg == 7'd0);
                            end else if (d1_reg == mbt_pkg::CC_RPN_LSB
                                         && coarse_set_reg[ch_idx]) begin
                                rpn_set_reg[ch_idx]  <= 1'b1;
                                rpn_zero_reg[ch_idx] <= coarse_zero_reg[ch_idx]
                                                        && (d2_reg == 7'd0);
                            end else if (d1_reg == mbt_pkg::CC_DATA_ENTRY
                                         && rpn_set_reg[ch_idx] && rpn_zero_reg[ch_idx]) begin
                                bend_range_reg <= {d2_reg, 1'b0};
                            end else begin
                                bend_range_reg <= bend_range_reg;
                            end
                        end
                    end
                end

                ST_READ: begin
                    // A note-off with no record falls back to no shift
                    shift_reg <= rd_data_reg.playing ? rd_data_reg.shift : 8'd0;
                    state_reg <= ST_EMIT;
                end

                ST_SWEEP: begin
                    sweep_reg <= sweep_reg + 1'b1;
                    if (&sweep_reg[6:0]) begin
                        state_reg <= ST_EMIT;
                    end
                end

                ST_MUL: begin
                    acc_reg   <= sum;
                    mcand_reg <= {mcand_reg[mbt_pkg::ACC_W-2:0], 1'b0};
                    mplr_reg  <= {1'b0, mplr_reg[7:1]};
                    cnt_reg   <= cnt_reg + 1'b1;
                    if (cnt_reg == 3'd7) begin
                        state_reg <= ST_DIV;
                    end
                end

                ST_DIV: begin
                    // Keep the trial difference only where it stays non-negative
                    if (!sum[mbt_pkg::ACC_W-1]) begin
                        acc_reg <= sum;
                    end
                    quo_reg <= quo_next;
                    dvs_reg <= dvs_reg >>> 1;
                    cnt_reg <= cnt_reg + 1'b1;
                    if (cnt_reg == 3'd7) begin
                        // Remove the +128 bias put in by the offset
                        chan_shift_reg[ch_idx] <= {~quo_next[7], quo_next[6:0]};
                        state_reg              <= ST_IDLE;
                    end
                end

                ST_EMIT: begin
                    // Hold until the output register is free
                    if (!m_valid_reg || m_ready) begin
                        m_valid_reg  <= 1'b1;
                        m_status_reg <= {kind_reg, och};
                        m_d1_reg     <= d1_reg + shift_reg[6:0];
                        m_d2_reg     <= d2_reg;
                        state_reg    <= ST_IDLE;
                    end
                end

                default: begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

endmodule

`default_nettype wire
